/* rtl/leader_color_clustering_core_macros.svh */
// Assertion macros for the leader color clustering core.
`ifndef LEADER_COLOR_CLUSTERING_CORE_MACROS_SVH
`define LEADER_COLOR_CLUSTERING_CORE_MACROS_SVH
`ifndef SYNTH
`define LCC_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");
`define LCC_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");
`else
`define LCC_ASSERT_IMPL(label, clk, rst_n, ante, cons)
`define LCC_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif
`endif

/* rtl/lcc_pkg.sv */
// Package with shared constants of the leader color clustering core.
package lcc_pkg;
  localparam int unsigned ColorW = 8;
  localparam int unsigned LumaW  = 18;
  localparam int unsigned LumaR  = 306;
  localparam int unsigned LumaG  = 601;
  localparam int unsigned LumaB  = 117;
  localparam int unsigned LabelW = 8;
  localparam int unsigned SizeW  = 23;
  localparam int unsigned CThrW  = 9;
  localparam int unsigned BThrW  = 18;
  localparam logic CFG_COLOR_THR  = 1'b0;
  localparam logic CFG_BRIGHT_THR = 1'b1;
endpackage

/* rtl/leader_color_clustering_core.sv */
// Top level of the leader color clustering core.
// Usage: present a pixel on in_red/in_green/in_blue with in_frame_start and
// pulse start while busy is low; the transaction is taken at that edge.
// in_frame_start empties the cluster table before the pixel is handled.
// The core then scans every cluster in use. For each entry it reads the
// sums, runs the shared serial divider three times (one mean channel each),
// and then checks color distance and brightness. The loop over entries and
// the single divider set the rate; items are handled one at a time.
// The result appears for one cycle with out_valid high; the receiver cannot
// stall, so it must take it then.
// Configuration writes go through cfg_valid/cfg_ready with cfg_index 0 for
// the color threshold and 1 for the brightness threshold; cfg_ready is
// always high. Write only while the core is idle.
// Reset clears the table fill count, the sequencer and sets the thresholds
// to 40 and 15360. The sum memories need no clearing: only filled entries
// are read.
`include "leader_color_clustering_core_macros.svh"
module leader_color_clustering_core #(
  parameter int unsigned MAX_CLUSTERS    = 256,
  parameter int unsigned MAX_PIXELS_LOG2 = 22
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic [7:0]  in_red,
  input  logic [7:0]  in_green,
  input  logic [7:0]  in_blue,
  input  logic        in_frame_start,
  output logic        out_valid,
  output logic [7:0]  out_cluster_label,
  output logic        out_opened_new,
  output logic        out_table_full,
  output logic [22:0] out_cluster_size,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic        cfg_index,
  input  logic [17:0] cfg_data
);
  localparam int unsigned IW  = $clog2(MAX_CLUSTERS);
  localparam int unsigned NCW = $clog2(MAX_CLUSTERS + 1);
  localparam int unsigned CNW = MAX_PIXELS_LOG2 + 1;
  localparam int unsigned SW  = CNW + 8;
  localparam int unsigned LW  = CNW + 18;
  localparam logic [CNW-1:0] CAP = CNW'(1) << MAX_PIXELS_LOG2;

  typedef enum logic [2:0] {
    S_IDLE, S_READ, S_DIV, S_CHECK, S_UPDATE, S_DONE
  } state_t;

  state_t state_r;
  logic [lcc_pkg::CThrW-1:0] cthr_r;
  logic [lcc_pkg::BThrW-1:0] bthr_r;
  logic [NCW-1:0] n_r;
  logic [IW-1:0]  idx_r;
  logic [1:0]     ch_r;
  logic [7:0]     red_r, green_r, blue_r;
  logic [lcc_pkg::LumaW-1:0] luma_r;
  logic           found_r;
  logic [17:0]    best_r;
  logic [IW-1:0]  win_r;
  logic [17:0]    dist_r;

  logic [SW-1:0]  mem_r_r [MAX_CLUSTERS];
  logic [SW-1:0]  mem_g_r [MAX_CLUSTERS];
  logic [SW-1:0]  mem_b_r [MAX_CLUSTERS];
  logic [LW-1:0]  mem_l_r [MAX_CLUSTERS];
  logic [CNW-1:0] mem_c_r [MAX_CLUSTERS];
  logic [SW-1:0]  rd_r_r, rd_g_r, rd_b_r;
  logic [LW-1:0]  rd_l_r;
  logic [CNW-1:0] rd_c_r;

  logic           mem_we;
  logic [IW-1:0]  mem_wa;
  logic [SW-1:0]  wd_r, wd_g, wd_b;
  logic [LW-1:0]  wd_l;
  logic [CNW-1:0] wd_c;
  logic [IW-1:0]  mem_ra;

  logic           div_start, div_done;
  logic [SW-1:0]  div_num, div_q;
  logic [7:0]     mean, pix, ad;
  logic [17:0]    dist_sum;
  logic [LW-1:0]  lc, ldiff;
  logic [LW-1:0]  blim;

  assign cfg_ready = 1'b1;
  assign busy = (state_r != S_IDLE);

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem_r_r[mem_wa] <= wd_r;
      mem_g_r[mem_wa] <= wd_g;
      mem_b_r[mem_wa] <= wd_b;
      mem_l_r[mem_wa] <= wd_l;
      mem_c_r[mem_wa] <= wd_c;
    end
    rd_r_r <= mem_r_r[mem_ra];
    rd_g_r <= mem_g_r[mem_ra];
    rd_b_r <= mem_b_r[mem_ra];
    rd_l_r <= mem_l_r[mem_ra];
    rd_c_r <= mem_c_r[mem_ra];
  end

  assign mem_ra = (state_r == S_UPDATE) ? win_r : idx_r;

  always_comb begin
    unique case (ch_r)
      2'd0:    div_num = rd_r_r;
      2'd1:    div_num = rd_g_r;
      default: div_num = rd_b_r;
    endcase
    unique case (ch_r)
      2'd0:    pix = red_r;
      2'd1:    pix = green_r;
      default: pix = blue_r;
    endcase
  end

  lcc_divider #(.NW(SW), .DW(CNW)) u_div (
    .clk(clk), .rst_n(rst_n), .start(div_start), .numer(div_num),
    .denom(rd_c_r), .done(div_done), .quot(div_q)
  );

  assign mean     = div_q[7:0];
  assign ad       = (pix > mean) ? pix - mean : mean - pix;
  assign dist_sum = dist_r + 18'(ad) * 18'(ad);
  assign lc       = LW'(luma_r) * LW'(rd_c_r);
  assign ldiff    = (lc > rd_l_r) ? lc - rd_l_r : rd_l_r - lc;
  assign blim     = LW'(bthr_r) * LW'(rd_c_r);

  always_comb begin
    mem_we = 1'b0;
    mem_wa = win_r;
    wd_r = rd_r_r + SW'(red_r);
    wd_g = rd_g_r + SW'(green_r);
    wd_b = rd_b_r + SW'(blue_r);
    wd_l = rd_l_r + LW'(luma_r);
    wd_c = rd_c_r + 1'b1;
    if (state_r == S_DONE) begin
      if (found_r) begin
        mem_we = (rd_c_r < CAP);
      end else if (n_r < NCW'(MAX_CLUSTERS)) begin
        mem_we = 1'b1;
        mem_wa = IW'(n_r);
        wd_r = SW'(red_r);
        wd_g = SW'(green_r);
        wd_b = SW'(blue_r);
        wd_l = LW'(luma_r);
        wd_c = CNW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= S_IDLE;
      cthr_r    <= 9'd40;
      bthr_r    <= 18'd15360;
      n_r       <= '0;
      out_valid <= 1'b0;
      div_start <= 1'b0;
    end else begin
      out_valid <= 1'b0;
      div_start <= 1'b0;
      if (cfg_valid && cfg_ready) begin
        priority if (cfg_index == lcc_pkg::CFG_COLOR_THR) cthr_r <= cfg_data[8:0];
        else bthr_r <= cfg_data;
      end
      unique case (state_r)
        S_IDLE: if (start) begin
          red_r   <= in_red;
          green_r <= in_green;
          blue_r  <= in_blue;
          luma_r  <= lcc_pkg::LumaW'(lcc_pkg::LumaR * in_red + lcc_pkg::LumaG * in_green
                     + lcc_pkg::LumaB * in_blue);
          found_r <= 1'b0;
          idx_r   <= '0;
          win_r   <= '0;
          if (in_frame_start) n_r <= '0;
          if (in_frame_start || n_r == '0) state_r <= S_UPDATE;
          else state_r <= S_READ;
        end
        S_READ: begin
          // the entry read is registered; then start the red division
          ch_r      <= 2'd0;
          dist_r    <= '0;
          div_start <= 1'b1;
          state_r   <= S_DIV;
        end
        S_DIV: if (div_done) begin
          dist_r <= dist_sum;
          if (ch_r == 2'd2) state_r <= S_CHECK;
          else begin
            ch_r      <= ch_r + 1'b1;
            div_start <= 1'b1;
          end
        end
        S_CHECK: begin
          if ((dist_r <= 18'(cthr_r) * 18'(cthr_r)) && (ldiff <= blim)
              && (!found_r || dist_r < best_r)) begin
            found_r <= 1'b1;
            best_r  <= dist_r;
            win_r   <= idx_r;
          end
          if (NCW'(idx_r) + 1'b1 >= n_r) state_r <= S_UPDATE;
          else begin
            idx_r   <= idx_r + 1'b1;
            state_r <= S_READ;
          end
        end
        S_UPDATE: begin
          // read the winner entry; its data is valid in the next cycle,
          // where the entry is written back
          state_r <= S_DONE;
        end
        S_DONE: begin
          out_valid <= 1'b1;
          if (found_r) begin
            out_cluster_label <= 8'(win_r);
            out_opened_new    <= 1'b0;
            out_table_full    <= 1'b0;
            out_cluster_size  <= 23'((rd_c_r < CAP) ? rd_c_r + 1'b1 : rd_c_r);
          end else if (n_r < NCW'(MAX_CLUSTERS)) begin
            out_cluster_label <= 8'(n_r);
            out_opened_new    <= 1'b1;
            out_table_full    <= 1'b0;
            out_cluster_size  <= 23'd1;
            n_r <= n_r + 1'b1;
          end else begin
            out_cluster_label <= '0;
            out_opened_new    <= 1'b0;
            out_table_full    <= 1'b1;
            out_cluster_size  <= '0;
          end
          state_r <= S_IDLE;
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  `LCC_ASSERT_IMPL(a_fill_bound, clk, rst_n, 1'b1, n_r <= NCW'(MAX_CLUSTERS))
  `LCC_ASSERT_NEXT(a_result_ends, clk, rst_n, out_valid, !out_valid)
  `LCC_ASSERT_IMPL(a_one_flag, clk, rst_n, out_valid, !(out_opened_new && out_table_full))
endmodule

/* rtl/lcc_divider.sv */
// Shared restoring divider: one quotient bit per cycle.
module lcc_divider #(
  parameter int unsigned NW = 30,
  parameter int unsigned DW = 27
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          start,
  input  logic [NW-1:0] numer,
  input  logic [DW-1:0] denom,
  output logic          done,
  output logic [NW-1:0] quot
);
  localparam int unsigned CW = $clog2(NW + 1);
  logic [NW-1:0] q_r;
  logic [DW:0]   rem_r;
  logic [DW-1:0] d_r;
  logic [CW-1:0] cnt_r;
  logic          busy_r;
  logic [DW:0]   trial;
  logic [DW:0]   diff;

  assign trial = {rem_r[DW-1:0], q_r[NW-1]};
  assign diff  = trial - {1'b0, d_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done   <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        q_r    <= numer;
        rem_r  <= '0;
        d_r    <= denom;
        cnt_r  <= CW'(NW);
      end else if (busy_r) begin
        if (!diff[DW]) begin
          rem_r <= diff;
          q_r   <= {q_r[NW-2:0], 1'b1};
        end else begin
          rem_r <= trial;
          q_r   <= {q_r[NW-2:0], 1'b0};
        end
        cnt_r <= cnt_r - 1'b1;
        if (cnt_r == CW'(1)) begin
          busy_r <= 1'b0;
          done   <= 1'b1;
        end
      end
    end
  end
  assign quot = q_r;
endmodule

/* bench/tb_leader_color_clustering_core.sv */
// Self-checking testbench for the leader color clustering core.
module tb_leader_color_clustering_core;

  localparam int unsigned NumClusters = 256;
  localparam int unsigned PixelCap    = 1 << 22;
  // The worst item scans a full table.
  localparam int unsigned StallLimit  = 200000;

  typedef struct packed {
    logic [lcc_pkg::LabelW-1:0] label;
    logic                       opened;
    logic                       full;
    logic [lcc_pkg::SizeW-1:0]  size;
  } pixel_verdict_t;

  logic             clk;
  logic             rst_n;
  logic             start;
  logic             busy;
  logic [7:0]       in_red;
  logic [7:0]       in_green;
  logic [7:0]       in_blue;
  logic             in_frame_start;
  logic             out_valid;
  logic [7:0]       out_cluster_label;
  logic             out_opened_new;
  logic             out_table_full;
  logic [22:0]      out_cluster_size;
  logic             cfg_valid;
  logic             cfg_ready;
  logic             cfg_index;
  logic [17:0]      cfg_data;

  leader_color_clustering_core u_top (
    .clk              (clk),
    .rst_n            (rst_n),
    .start            (start),
    .busy             (busy),
    .in_red           (in_red),
    .in_green         (in_green),
    .in_blue          (in_blue),
    .in_frame_start   (in_frame_start),
    .out_valid        (out_valid),
    .out_cluster_label(out_cluster_label),
    .out_opened_new   (out_opened_new),
    .out_table_full   (out_table_full),
    .out_cluster_size (out_cluster_size),
    .cfg_valid        (cfg_valid),
    .cfg_ready        (cfg_ready),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data)
  );

  // 8-unit clock period.
  initial clk = 1'b0;
  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // Shadow copy of the cluster table and the thresholds.
  longint unsigned red_sum   [NumClusters];
  longint unsigned green_sum [NumClusters];
  longint unsigned blue_sum  [NumClusters];
  longint unsigned luma_sum  [NumClusters];
  longint unsigned pix_count [NumClusters];
  int unsigned     live_clusters;
  logic [lcc_pkg::CThrW-1:0] color_thr;
  logic [lcc_pkg::BThrW-1:0] bright_thr;

  pixel_verdict_t verdict_q[$];
  int unsigned    fail_count;
  int unsigned    pixels_sent;
  int unsigned    verdicts_seen;
  int unsigned    opened_seen;
  int unsigned    full_seen;
  int unsigned    joined_seen;
  int unsigned    stall_cycles;
  bit             idle_on;

  // Assign one pixel to a cluster and update the shadow table.
  function automatic pixel_verdict_t assign_pixel(logic [7:0] r, logic [7:0] g,
                                                   logic [7:0] b, logic fs);
    pixel_verdict_t  v;
    longint unsigned luma, thr2, best, sq_dist, lc, diff, cnt, dr, dg, db;
    int unsigned     win;
    bit              hit;
    luma = lcc_pkg::LumaR * r + lcc_pkg::LumaG * g + lcc_pkg::LumaB * b;
    thr2 = longint'(color_thr) * color_thr;
    hit  = 0;
    best = 0;
    win  = 0;
    if (fs) live_clusters = 0;
    for (int unsigned i = 0; i < live_clusters; i++) begin
      cnt = pix_count[i];
      if (cnt == 0) continue;
      dr = red_sum[i] / cnt;
      dg = green_sum[i] / cnt;
      db = blue_sum[i] / cnt;
      dr = (r > dr) ? r - dr : dr - r;
      dg = (g > dg) ? g - dg : dg - g;
      db = (b > db) ? b - db : db - b;
      sq_dist = dr * dr + dg * dg + db * db;
      lc   = luma * cnt;
      diff = (lc > luma_sum[i]) ? lc - luma_sum[i] : luma_sum[i] - lc;
      if (sq_dist <= thr2 && diff <= longint'(bright_thr) * cnt) begin
        if (!hit || sq_dist < best) begin
          hit  = 1;
          best = sq_dist;
          win  = i;
        end
      end
    end
    v = '0;
    if (hit) begin
      // A saturated cluster keeps its sums and count.
      if (pix_count[win] < PixelCap) begin
        red_sum[win]   += r;
        green_sum[win] += g;
        blue_sum[win]  += b;
        luma_sum[win]  += luma;
        pix_count[win] += 1;
      end
      v.label = win[7:0];
      v.size  = pix_count[win][22:0];
    end else if (live_clusters < NumClusters) begin
      red_sum[live_clusters]   = r;
      green_sum[live_clusters] = g;
      blue_sum[live_clusters]  = b;
      luma_sum[live_clusters]  = luma;
      pix_count[live_clusters] = 1;
      v.label  = live_clusters[7:0];
      v.opened = 1'b1;
      v.size   = 1;
      live_clusters++;
    end else begin
      v.full = 1'b1;
    end
    return v;
  endfunction

  // Present one pixel and hold it until the core takes the transaction.
  // Start stays high on return unless a random idle burst has dropped it.
  task automatic send_pixel(logic [7:0] r, logic [7:0] g, logic [7:0] b, logic fs);
    pixel_verdict_t v;
    in_red         <= r;
    in_green       <= g;
    in_blue        <= b;
    in_frame_start <= fs;
    start          <= 1'b1;
    do @(posedge clk); while (busy);
    v = assign_pixel(r, g, b, fs);
    verdict_q.insert(verdict_q.size(), v);
    pixels_sent++;
    if (idle_on && $urandom_range(0, 2) == 0) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 11)) @(posedge clk);
    end
  endtask

  // Drop start and wait until every expected verdict has arrived.
  task automatic drain;
    start <= 1'b0;
    do @(posedge clk); while (verdict_q.size() != 0);
    repeat (4) @(posedge clk);
  endtask

  // Write one threshold register; the core must be idle.
  task automatic write_threshold(logic idx, logic [17:0] value);
    drain();
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    if (idx == lcc_pkg::CFG_COLOR_THR) color_thr = value[lcc_pkg::CThrW-1:0];
    else                               bright_thr = value[lcc_pkg::BThrW-1:0];
  endtask

  // Compare each verdict against the oldest prediction.
  always @(posedge clk) begin
    if (rst_n && out_valid) begin
      verdicts_seen++;
      if (verdict_q.size() == 0) begin
        $display("%0t: unexpected verdict label=%0d", $time, out_cluster_label);
        fail_count++;
      end else begin
        pixel_verdict_t e;
        e = verdict_q.pop_front();
        if (e.opened) opened_seen++;
        else if (e.full) full_seen++;
        else joined_seen++;
        if (out_cluster_label !== e.label) begin
          $display("%0t: label exp %0d got %0d", $time, e.label, out_cluster_label);
          fail_count++;
        end
        if (out_opened_new !== e.opened) begin
          $display("%0t: opened_new exp %0b got %0b", $time, e.opened, out_opened_new);
          fail_count++;
        end
        if (out_table_full !== e.full) begin
          $display("%0t: table_full exp %0b got %0b", $time, e.full, out_table_full);
          fail_count++;
        end
        if (out_cluster_size !== e.size) begin
          $display("%0t: size exp %0d got %0d", $time, e.size, out_cluster_size);
          fail_count++;
        end
      end
    end
  end

  // Watchdog: end the run if no transaction moves for too long.
  always @(posedge clk) begin
    if ((start && !busy) || out_valid || (cfg_valid && cfg_ready) || !rst_n)
      stall_cycles <= 0;
    else
      stall_cycles <= stall_cycles + 1;
    if (stall_cycles >= StallLimit) begin
      $display("leader_color_clustering_core test failed");
      $finish;
    end
  end

  // Extremes, truncated means, a match right at the distance limit.
  task automatic test_directed_pixels;
    send_pixel(8'd0, 8'd0, 8'd0, 1'b1);
    send_pixel(8'd1, 8'd0, 8'd0, 1'b0);     // joins, mean stays 0
    send_pixel(8'd0, 8'd1, 8'd1, 1'b0);
    send_pixel(8'd255, 8'd255, 8'd255, 1'b0);
    send_pixel(8'd254, 8'd255, 8'd255, 1'b0);
    send_pixel(8'd10, 8'd128, 8'd128, 1'b1);
    send_pixel(8'd50, 8'd128, 8'd128, 1'b0); // distance 40, at the limit
    send_pixel(8'd30, 8'd128, 8'd128, 1'b0); // lands on the cluster mean
    send_pixel(8'd170, 8'd85, 8'd170, 1'b0);
    send_pixel(8'd85, 8'd170, 8'd85, 1'b0);
  endtask

  // Thresholds at both extremes, written back to defaults afterward.
  task automatic test_threshold_extremes;
    write_threshold(lcc_pkg::CFG_COLOR_THR, 18'd0);
    write_threshold(lcc_pkg::CFG_BRIGHT_THR, 18'd0);
    send_pixel(8'd100, 8'd100, 8'd100, 1'b1);
    send_pixel(8'd100, 8'd100, 8'd100, 1'b0);
    send_pixel(8'd101, 8'd100, 8'd100, 1'b0);
    write_threshold(lcc_pkg::CFG_COLOR_THR, 18'h1FF);
    write_threshold(lcc_pkg::CFG_BRIGHT_THR, 18'h3FFFF);
    send_pixel(8'd0, 8'd0, 8'd0, 1'b1);
    send_pixel(8'd255, 8'd255, 8'd255, 1'b0);
    write_threshold(lcc_pkg::CFG_COLOR_THR, 18'd442);
    write_threshold(lcc_pkg::CFG_BRIGHT_THR, 18'd261120);
    send_pixel(8'd255, 8'd0, 8'd255, 1'b1);
    send_pixel(8'd0, 8'd255, 8'd0, 1'b0);
    write_threshold(lcc_pkg::CFG_COLOR_THR, 18'd400);
    write_threshold(lcc_pkg::CFG_BRIGHT_THR, 18'd20);
    send_pixel(8'd0, 8'd0, 8'd0, 1'b1);
    send_pixel(8'd0, 8'd0, 8'd1, 1'b0);      // luma off by 117: new cluster
    write_threshold(lcc_pkg::CFG_COLOR_THR, 18'd40);
    write_threshold(lcc_pkg::CFG_BRIGHT_THR, 18'd15360);
  endtask

  // Fill all entries, then overflow, then hit an existing entry.
  task automatic test_table_full;
    write_threshold(lcc_pkg::CFG_COLOR_THR, 18'd0);
    write_threshold(lcc_pkg::CFG_BRIGHT_THR, 18'd0);
    for (int i = 0; i < NumClusters; i++)
      send_pixel(i[7:0], ~i[7:0], i[7:0] ^ 8'h5A, i == 0);
    send_pixel(8'd7, 8'd7, 8'd7, 1'b0);
    send_pixel(8'd255, 8'd255, 8'd0, 1'b0);
    send_pixel(8'd255, 8'd0, 8'd255 ^ 8'h5A, 1'b0);
    send_pixel(8'd3, 8'd3, 8'd3, 1'b1);      // frame start frees the table
    write_threshold(lcc_pkg::CFG_COLOR_THR, 18'd40);
    write_threshold(lcc_pkg::CFG_BRIGHT_THR, 18'd15360);
  endtask

  // Short frames of pixels scattered around a few random centers, with random threshold writes.
  task automatic test_random_frames(int unsigned pixel_total);
    int unsigned sent;
    int unsigned frame_len;
    int unsigned spread;
    logic [7:0]  centers [4][3];
    logic [7:0]  px [3];
    sent = 0;
    while (sent < pixel_total) begin
      if ($urandom_range(0, 3) == 0) begin
        case ($urandom_range(0, 3))
          0: write_threshold(lcc_pkg::CFG_COLOR_THR, 18'($urandom_range(0, 511)));
          1: write_threshold(lcc_pkg::CFG_BRIGHT_THR, 18'($urandom_range(0, 262143)));
          2: write_threshold(lcc_pkg::CFG_COLOR_THR, 18'($urandom_range(5, 80)));
          default: write_threshold(lcc_pkg::CFG_BRIGHT_THR,
                                   18'($urandom_range(1000, 40000)));
        endcase
      end
      foreach (centers[k, c]) centers[k][c] = 8'($urandom_range(0, 255));
      frame_len = $urandom_range(1, 20);
      spread    = $urandom_range(0, 30);
      for (int unsigned n = 0; n < frame_len && sent < pixel_total; n++) begin
        if ($urandom_range(0, 7) == 0) begin
          foreach (px[c]) px[c] = 8'($urandom_range(0, 255));
        end else begin
          int unsigned k;
          k = $urandom_range(0, 3);
          foreach (px[c]) begin
            int v;
            v = int'(centers[k][c]) + int'($urandom_range(0, 2 * spread)) - int'(spread);
            px[c] = (v < 0) ? 8'd0 : (v > 255) ? 8'd255 : 8'(v);
          end
        end
        send_pixel(px[0], px[1], px[2], n == 0 || $urandom_range(0, 40) == 0);
        sent++;
      end
    end
  endtask

  initial begin
    int unsigned tail;
    rst_n          <= 1'b0;
    start          <= 1'b0;
    in_red         <= '0;
    in_green       <= '0;
    in_blue        <= '0;
    in_frame_start <= 1'b0;
    cfg_valid      <= 1'b0;
    cfg_index      <= lcc_pkg::CFG_COLOR_THR;
    cfg_data       <= '0;
    fail_count     = 0;
    pixels_sent    = 0;
    verdicts_seen  = 0;
    opened_seen    = 0;
    full_seen      = 0;
    joined_seen    = 0;
    live_clusters  = 0;
    color_thr      = 40;
    bright_thr     = 15360;
    idle_on        = 1'b1;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_directed_pixels();
    test_threshold_extremes();
    test_table_full();
    test_random_frames(120);
    idle_on = 1'b0;
    test_random_frames(20);
    idle_on = 1'b1;
    test_random_frames(100);
    // Final stretch runs back to back.
    idle_on = 1'b0;
    test_random_frames(60);

    drain();
    tail = 0;
    while (tail < 200) begin
      @(posedge clk);
      tail++;
    end
    $display("Ran %0d pixels: %0d verdicts, %0d opened, %0d joined, %0d table full.",
             pixels_sent, verdicts_seen, opened_seen, joined_seen, full_seen);
    $display("Covered threshold extremes, full table, saturation-free joins and random frames.");
    if (fail_count == 0 && verdict_q.size() == 0) begin
      $display("leader_color_clustering_core test passed");
    end else begin
      $display("leader_color_clustering_core test failed");
    end
    $finish;
  end

endmodule
